// ===== rtl/gbs_pkg.sv =====
// package: constants, types and helpers shared by the box suppression block
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int MAX_KEPT  = 256;
    localparam int KEPT_AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W     = $clog2(MAX_KEPT + 1);
    localparam int COORD_W   = 16;
    localparam int LABEL_W   = 8;
    localparam int AREA_W    = 2 * COORD_W;
    localparam int UNION_W   = AREA_W + 1;
    localparam int THR_W     = 9;
    localparam int PROD_W    = THR_W + UNION_W;
    localparam int SEQ_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ENTRY_W   = LABEL_W + AREA_W + 4 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 9'd115;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic accept;
        logic calc_area;
        logic issue;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic busy;
        logic out_free;
    } status_t;

    function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                 input logic [COORD_W-1:0] hi);
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

    function automatic logic [COORD_W-1:0] overlap(input logic [COORD_W-1:0] a0,
                                                    input logic [COORD_W-1:0] a1,
                                                    input logic [COORD_W-1:0] b0,
                                                    input logic [COORD_W-1:0] b1);
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        if ((a1 < a0) || (b1 < b0))
        begin
            overlap = '0;
        end
        else
        begin
            overlap = span(lo, hi);
        end
    endfunction

endpackage

// ===== rtl/gbs_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gbs_ctrl.sv =====
// controller state machine for the box suppression block
`timescale 1ns / 1ps

module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                state_next = status.count_zero ? ST_DECIDE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_AREA:
            begin
                cmd.calc_area = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            ST_DECIDE:
            begin
                cmd.decide = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/gbs_dpath.sv =====
// datapath: configuration registers, candidate latch, kept-box table, overlap pipeline and result register
`timescale 1ns / 1ps

module gbs_dpath
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [COORD_W-1:0]    left_edge,
    input  logic [COORD_W-1:0]    top_edge,
    input  logic [COORD_W-1:0]    right_edge,
    input  logic [COORD_W-1:0]    bottom_edge,
    input  logic [LABEL_W-1:0]    class_label,
    input  logic                  frame_end,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [SEQ_W-1:0]      proposal_number,
    output logic                  kept,
    output logic                  table_overflow,
    output logic                  frame_done
);

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic             agnostic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            agnostic_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_IOU_THRESHOLD)
            begin
                thr_reg <= cfg_data[THR_W-1:0];
            end
            else if (cfg_index == REG_CLASS_AGNOSTIC)
            begin
                agnostic_reg <= cfg_data[0];
            end
        end
    end

    // candidate latch
    logic [COORD_W-1:0] cl_reg;
    logic [COORD_W-1:0] ct_reg;
    logic [COORD_W-1:0] cr_reg;
    logic [COORD_W-1:0] cb_reg;
    logic [LABEL_W-1:0] clab_reg;
    logic               clast_reg;
    logic [AREA_W-1:0]  carea_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cl_reg    <= left_edge;
            ct_reg    <= top_edge;
            cr_reg    <= right_edge;
            cb_reg    <= bottom_edge;
            clab_reg  <= class_label;
            clast_reg <= frame_end;
        end
        if (cmd.calc_area)
        begin
            carea_reg <= AREA_W'(span(cl_reg, cr_reg)) * AREA_W'(span(ct_reg, cb_reg));
        end
    end

    // table control
    logic [CNT_W-1:0]   count_reg;
    logic [KEPT_AW-1:0] idx_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic               suppress_reg;
    logic               store;

    assign store = cmd.decide && !suppress_reg && (count_reg < CNT_W'(MAX_KEPT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.decide)
            begin
                if (clast_reg)
                begin
                    count_reg <= '0;
                    seq_reg   <= '0;
                end
                else
                begin
                    seq_reg <= seq_reg + 1'b1;
                    if (store)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
        end
    end

    // kept-box table
    logic [ENTRY_W-1:0] rd_word;
    logic [ENTRY_W-1:0] wr_word;

    assign wr_word = {clab_reg, carea_reg, cb_reg, cr_reg, ct_reg, cl_reg};

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_table (
        .clk   (clk),
        .we    (store),
        .waddr (KEPT_AW'(count_reg)),
        .wdata (wr_word),
        .raddr (idx_reg),
        .rdata (rd_word)
    );

    // overlap pipeline
    logic [COORD_W-1:0] kl;
    logic [COORD_W-1:0] kt;
    logic [COORD_W-1:0] kr;
    logic [COORD_W-1:0] kb;
    logic [AREA_W-1:0]  ka;
    logic [LABEL_W-1:0] klab;

    assign {klab, ka, kb, kr, kt, kl} = rd_word;

    logic               p1_reg;
    logic               p2_reg;
    logic               p3_reg;
    logic               p4_reg;
    logic               p5_reg;
    logic [COORD_W-1:0] ox_reg;
    logic [COORD_W-1:0] oy_reg;
    logic [AREA_W-1:0]  ka2_reg;
    logic [AREA_W-1:0]  inter3_reg;
    logic [AREA_W-1:0]  ka3_reg;
    logic [AREA_W-1:0]  inter4_reg;
    logic [UNION_W-1:0] uni4_reg;
    logic [AREA_W-1:0]  inter5_reg;
    logic [PROD_W-1:0]  prod5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            p3_reg       <= 1'b0;
            p4_reg       <= 1'b0;
            p5_reg       <= 1'b0;
            suppress_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= cmd.issue;
            p2_reg <= p1_reg && (agnostic_reg || (klab == clab_reg));
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
            if (cmd.accept)
            begin
                suppress_reg <= 1'b0;
            end
            else if (p5_reg && ({2'b00, inter5_reg, 8'h00} > prod5_reg))
            begin
                suppress_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg     <= overlap(cl_reg, cr_reg, kl, kr);
        oy_reg     <= overlap(ct_reg, cb_reg, kt, kb);
        ka2_reg    <= ka;
        inter3_reg <= AREA_W'(ox_reg) * AREA_W'(oy_reg);
        ka3_reg    <= ka2_reg;
        inter4_reg <= inter3_reg;
        uni4_reg   <= UNION_W'(carea_reg) + UNION_W'(ka3_reg) - UNION_W'(inter3_reg);
        inter5_reg <= inter4_reg;
        prod5_reg  <= PROD_W'(thr_reg) * PROD_W'(uni4_reg);
    end

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            proposal_number <= seq_reg;
            kept            <= store;
            table_overflow  <= !suppress_reg && !store;
            frame_done      <= clast_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign status.busy       = p1_reg || p2_reg || p3_reg || p4_reg || p5_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

endmodule

// ===== rtl/greedy_box_suppression.sv =====
// greedy box suppression by intersection over union, one candidate at a time
//
// input channel: in_valid / in_stall with box edges (unsigned q12.4), class_label and
// frame_end; a word is taken when in_valid is high and in_stall is low. candidates of a
// frame come in descending score order. the block holds one candidate at a time.
// output channel: out_valid / out_stall with proposal_number, kept, table_overflow and
// frame_done, one word per candidate, in input order.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 = iou_threshold
// (q1.8), 1 = class_agnostic; other indexes are ignored. write only while idle.
// flow: after accept the candidate area is computed, then each box in the kept table is
// read from the kept-box ram one entry per cycle and sent through the overlap pipeline;
// once it drains the result is registered. with an empty table the scan is skipped.
// a stalled result sits in the output register while the next candidate is processed;
// the block waits only when that next result is ready and the register is still full.
// reset: threshold 115, class_agnostic 0, empty table, numbering from 0, no result held.
`timescale 1ns / 1ps

module greedy_box_suppression
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_W-1:0]    left_edge,
    input  logic [COORD_W-1:0]    top_edge,
    input  logic [COORD_W-1:0]    right_edge,
    input  logic [COORD_W-1:0]    bottom_edge,
    input  logic [LABEL_W-1:0]    class_label,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SEQ_W-1:0]      proposal_number,
    output logic                  kept,
    output logic                  table_overflow,
    output logic                  frame_done,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gbs_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .left_edge       (left_edge),
        .top_edge        (top_edge),
        .right_edge      (right_edge),
        .bottom_edge     (bottom_edge),
        .class_label     (class_label),
        .frame_end       (frame_end),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .proposal_number (proposal_number),
        .kept            (kept),
        .table_overflow  (table_overflow),
        .frame_done      (frame_done)
    );

endmodule

// ===== rtl/gbs_checker.sv =====
// port-level checker for the box suppression block, bound to the top level
`timescale 1ns / 1ps

module gbs_checker
    import gbs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  kept,
    input logic                  table_overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while a candidate is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_idle_with_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("new result without returning to idle");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(kept && table_overflow))
        else $error("kept and table_overflow both set");

endmodule

bind greedy_box_suppression gbs_checker u_checker (.*);
